/* sv/rau_pkg.sv */
`timescale 1ns / 1ps
package rau_pkg;

  // operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_LT  = 3'd4;
  localparam logic [2:0] OP_GT  = 3'd5;
  localparam logic [2:0] OP_EQ  = 3'd6;
  localparam logic [2:0] OP_NRM = 3'd7;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NONE   = 4'd0,
    CMD_LOAD   = 4'd1,  // split inputs into sign and magnitude
    CMD_GCD_A  = 4'd2,  // start reduce of left operand
    CMD_GCD_B  = 4'd3,  // start reduce of right operand
    CMD_MUL1   = 4'd4,  // first products
    CMD_MUL2   = 4'd5,  // combine products
    CMD_GCD_R  = 4'd6,  // start reduce of result
    CMD_DIVA   = 4'd7,  // latch quotients of left operand
    CMD_DIVB   = 4'd8,  // latch quotients of right operand
    CMD_DIVR   = 4'd9,  // latch quotients of result
    CMD_GSTEP  = 4'd10, // one gcd/divide step
    CMD_FINISH = 4'd11  // build output
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } rau_ctl_t;

  typedef struct packed {
    logic busy;      // iterative unit still running
    logic a_err;     // left operand zero denominator
    logic b_err;     // right operand zero denominator
    logic b_zero;    // right operand is zero
  } rau_sts_t;

endpackage

/* sv/rau_ctrl.sv */
`timescale 1ns / 1ps
module rau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic [2:0]        op_i,
  input  logic              out_free_i,
  input  rau_pkg::rau_sts_t sts_i,
  output rau_pkg::rau_ctl_t ctl_o,
  output logic              idle_o,
  output logic              done_o
);
  import rau_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_LOAD  = 12'b000000000010,
    S_GA    = 12'b000000000100,
    S_WA    = 12'b000000001000,
    S_GB    = 12'b000000010000,
    S_WB    = 12'b000000100000,
    S_M1    = 12'b000001000000,
    S_M2    = 12'b000010000000,
    S_GR    = 12'b000100000000,
    S_WR    = 12'b001000000000,
    S_FIN   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [2:0] op_q;
  cmd_e cmd;

  // op kept for sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_ADD;
    end else if (in_fire_i) begin
      op_q <= op_i;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd = CMD_NONE;
    case (state_q)
      S_IDLE: if (in_fire_i) state_d = S_LOAD;
      S_LOAD: begin
        cmd = CMD_LOAD;
        state_d = S_GA;
      end
      S_GA: begin
        cmd = CMD_GCD_A;
        state_d = S_WA;
      end
      S_WA: begin
        if (sts_i.busy) begin
          cmd = CMD_GSTEP;
        end else begin
          cmd = CMD_DIVA;
          if (sts_i.a_err || op_q == OP_NRM) state_d = S_FIN;
          else state_d = S_GB;
        end
      end
      S_GB: begin
        cmd = CMD_GCD_B;
        state_d = S_WB;
      end
      S_WB: begin
        if (sts_i.busy) begin
          cmd = CMD_GSTEP;
        end else begin
          cmd = CMD_DIVB;
          state_d = S_M1;
        end
      end
      S_M1: begin
        cmd = CMD_MUL1;
        state_d = S_M2;
        if (sts_i.b_err || op_q == OP_EQ || (op_q == OP_DIV && sts_i.b_zero))
          state_d = S_FIN;
      end
      S_M2: begin
        cmd = CMD_MUL2;
        state_d = S_GR;
      end
      S_GR: begin
        cmd = CMD_GCD_R;
        state_d = S_WR;
      end
      S_WR: begin
        if (sts_i.busy) begin
          cmd = CMD_GSTEP;
        end else begin
          cmd = CMD_DIVR;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free_i) begin
          cmd = CMD_FINISH;
          state_d = S_OUT;
        end
      end
      S_OUT: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign ctl_o.cmd = cmd;
  assign idle_o = (state_q == S_IDLE);
  assign done_o = (cmd == CMD_FINISH);

  a_fire_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire_i |-> state_q == S_IDLE) else $error("item accepted while busy");
  a_fin_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == S_FIN) else $error("finish outside final state");
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> state_q == S_OUT) else $error("finish not followed by output");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
endmodule

/* sv/rau_dp.sv */
`timescale 1ns / 1ps
module rau_dp #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_fire_i,
  input  logic [2:0]               op_i,
  input  logic [VALUE_WIDTH-1:0]   an_i,
  input  logic [VALUE_WIDTH-1:0]   ad_i,
  input  logic [VALUE_WIDTH-1:0]   bn_i,
  input  logic [VALUE_WIDTH-1:0]   bd_i,
  input  rau_pkg::rau_ctl_t        ctl_i,
  output rau_pkg::rau_sts_t        sts_o,
  output logic [31:0]              res_num_o,
  output logic [30:0]              res_den_o,
  output logic                     cmp_o,
  output logic [1:0]               status_o
);
  import rau_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned MW = 2 * W + 1;   // sums of two products
  localparam int unsigned CW = $clog2(MW + 1);
  localparam logic [MW-1:0] LIMIT = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};

  // operand registers
  logic [2:0]    op_q;
  logic [W-1:0]  an_q, ad_q, bn_q, bd_q;
  logic          a_neg_q, b_neg_q, r_neg_q;
  logic [W:0]    a_mag_q, a_den_q, b_mag_q, b_den_q;
  logic          a_err_q, b_err_q;
  logic [MW-1:0] p1_q, p2_q, p3_q;
  logic [MW-1:0] rn_q, rd_q;     // value to reduce
  // gcd / divide unit
  logic [MW-1:0] x_q, y_q;       // euclid pair
  logic [MW-1:0] rem_q, quo_q;   // restoring divider
  logic [CW-1:0] bit_q;
  logic [1:0]    phase_q;        // 0 idle, 1 mod, 2 div num, 3 div den
  logic [MW-1:0] qn_q;
  // output
  logic [31:0]   res_num_q;
  logic [30:0]   res_den_q;
  logic          cmp_q;
  logic [1:0]    status_q;

  function automatic logic [W:0] mag_of(input logic [W-1:0] v);
    if (v[W-1]) mag_of = {1'b0, (~v) + 1'b1} | ({(W+1){v == {1'b1, {(W-1){1'b0}}}}}
                          & {1'b1, {W{1'b0}}} >> 1);
    else mag_of = {1'b0, v};
  endfunction

  // divider step: dividend in div_src, divisor y_q
  logic [MW-1:0] div_src;
  logic [MW:0]   trial;
  logic [MW-1:0] rem_sh;
  logic [MW-1:0] rem_new;
  logic          rem_zero;
  always_comb begin
    div_src  = (phase_q == 2'd1) ? x_q : ((phase_q == 2'd2) ? rn_q : rd_q);
    rem_sh   = {rem_q[MW-2:0], div_src[bit_q[CW-1:0]]};
    trial    = {1'b0, rem_sh} - {1'b0, y_q};
    rem_new  = trial[MW] ? rem_sh : trial[MW-1:0];
    rem_zero = (rem_new == '0);
  end

  logic busy;
  assign busy = (phase_q != 2'd0);

  // combine for add/sub
  logic          bflip;
  logic [MW-1:0] sum_mag;
  logic          sum_neg;
  always_comb begin
    bflip = (op_q == OP_ADD) ? b_neg_q : (b_mag_q != '0 && !b_neg_q);
    if (a_neg_q == bflip) begin
      sum_mag = p1_q + p2_q;
      sum_neg = a_neg_q;
    end else if (p1_q >= p2_q) begin
      sum_mag = p1_q - p2_q;
      sum_neg = a_neg_q;
    end else begin
      sum_mag = p2_q - p1_q;
      sum_neg = bflip;
    end
  end

  logic [MW-1:0] final_num;
  logic          ovf;
  logic          cmp_v;
  logic [1:0]    st_v;
  always_comb begin
    final_num = (op_q == OP_NRM) ? {{(MW-W-1){1'b0}}, a_mag_q} : rn_q;
    ovf = 1'b0;
    cmp_v = 1'b0;
    st_v = ST_OK;
    if (a_err_q || (op_q != OP_NRM && b_err_q)) begin
      st_v = ST_ZDEN;
    end else if (op_q == OP_DIV && b_mag_q == '0) begin
      st_v = ST_DIV0;
    end else if (op_q == OP_EQ) begin
      cmp_v = (a_neg_q == b_neg_q) && (a_mag_q == b_mag_q) && (a_den_q == b_den_q);
    end else if (op_q == OP_LT || op_q == OP_GT) begin
      if (rn_q != '0) cmp_v = (op_q == OP_LT) ? r_neg_q : !r_neg_q;
    end else begin
      if (op_q == OP_NRM) ovf = (a_mag_q > LIMIT[W:0]) || (a_den_q > LIMIT[W:0]);
      else ovf = (rn_q > LIMIT) || (rd_q > LIMIT);
      if (ovf) st_v = ST_OVF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
    end else begin
      case (ctl_i.cmd)
        CMD_GCD_A: phase_q <= (a_mag_q != '0 && a_den_q != '0) ? 2'd1 : 2'd0;
        CMD_GCD_B: phase_q <= (b_mag_q != '0 && b_den_q != '0) ? 2'd1 : 2'd0;
        CMD_GCD_R: phase_q <= (rn_q != '0 && rd_q != '0) ? 2'd1 : 2'd0;
        CMD_GSTEP: begin
          if (bit_q == '0) begin
            if (phase_q == 2'd1) begin
              if (rem_zero) phase_q <= 2'd2;
            end else if (phase_q == 2'd2) begin
              phase_q <= 2'd3;
            end else begin
              phase_q <= 2'd0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      op_q <= op_i;
      an_q <= an_i; ad_q <= ad_i; bn_q <= bn_i; bd_q <= bd_i;
    end
    case (ctl_i.cmd)
      CMD_LOAD: begin
        a_neg_q <= an_q[W-1] != ad_q[W-1];
        b_neg_q <= bn_q[W-1] != bd_q[W-1];
        a_mag_q <= mag_of(an_q); a_den_q <= mag_of(ad_q);
        b_mag_q <= mag_of(bn_q); b_den_q <= mag_of(bd_q);
        a_err_q <= (an_q != '0) && (ad_q == '0);
        b_err_q <= (bn_q != '0) && (bd_q == '0);
      end
      CMD_GCD_A: begin
        rn_q <= {{(MW-W-1){1'b0}}, a_mag_q};
        rd_q <= {{(MW-W-1){1'b0}}, a_den_q};
        x_q <= {{(MW-W-1){1'b0}}, a_mag_q};
        y_q <= {{(MW-W-1){1'b0}}, a_den_q};
        rem_q <= '0; bit_q <= CW'(MW - 1);
      end
      CMD_GCD_B: begin
        rn_q <= {{(MW-W-1){1'b0}}, b_mag_q};
        rd_q <= {{(MW-W-1){1'b0}}, b_den_q};
        x_q <= {{(MW-W-1){1'b0}}, b_mag_q};
        y_q <= {{(MW-W-1){1'b0}}, b_den_q};
        rem_q <= '0; bit_q <= CW'(MW - 1);
      end
      CMD_GCD_R: begin
        x_q <= rn_q; y_q <= rd_q;
        rem_q <= '0; bit_q <= CW'(MW - 1);
      end
      CMD_GSTEP: begin
        quo_q <= {quo_q[MW-2:0], !trial[MW]};
        if (bit_q != '0) begin
          rem_q <= rem_new;
          bit_q <= bit_q - 1'b1;
        end else begin
          rem_q <= '0;
          bit_q <= CW'(MW - 1);
          if (phase_q == 2'd1) begin
            // x mod y done; advance the euclid pair, y stays as the gcd
            // divisor for the quotient passes once the remainder is zero
            x_q <= y_q;
            if (!rem_zero) y_q <= rem_new;
          end else if (phase_q == 2'd2) begin
            qn_q <= {quo_q[MW-2:0], !trial[MW]};
          end
        end
      end
      CMD_DIVA: begin
        if (rn_q == '0) begin
          a_mag_q <= '0; a_den_q <= {{W{1'b0}}, 1'b1}; a_neg_q <= 1'b0;
        end else if (rd_q != '0) begin
          a_mag_q <= qn_q[W:0]; a_den_q <= quo_q[W:0];
        end
      end
      CMD_DIVB: begin
        if (rn_q == '0) begin
          b_mag_q <= '0; b_den_q <= {{W{1'b0}}, 1'b1}; b_neg_q <= 1'b0;
        end else if (rd_q != '0) begin
          b_mag_q <= qn_q[W:0]; b_den_q <= quo_q[W:0];
        end
      end
      CMD_MUL1: begin
        case (op_q)
          OP_MUL: begin
            p1_q <= MW'(a_mag_q * b_mag_q);
            p3_q <= MW'(a_den_q * b_den_q);
          end
          OP_DIV: begin
            p1_q <= MW'(a_mag_q * b_den_q);
            p3_q <= MW'(a_den_q * b_mag_q);
          end
          default: begin
            p1_q <= MW'(a_mag_q * b_den_q);
            p2_q <= MW'(b_mag_q * a_den_q);
            p3_q <= MW'(a_den_q * b_den_q);
          end
        endcase
      end
      CMD_MUL2: begin
        rd_q <= p3_q;
        if (op_q == OP_MUL || op_q == OP_DIV) begin
          rn_q <= p1_q;
          r_neg_q <= a_neg_q != b_neg_q;
        end else begin
          rn_q <= sum_mag;
          r_neg_q <= sum_neg;
        end
      end
      CMD_DIVR: begin
        if (rn_q == '0) begin
          rd_q <= {{(MW-1){1'b0}}, 1'b1}; r_neg_q <= 1'b0;
        end else begin
          rn_q <= qn_q; rd_q <= quo_q;
        end
      end
      CMD_FINISH: begin
        cmp_q <= cmp_v;
        status_q <= st_v;
        if (st_v != ST_OK || op_q == OP_EQ || op_q == OP_LT || op_q == OP_GT) begin
          res_num_q <= '0;
          res_den_q <= 31'd1;
        end else if (op_q == OP_NRM) begin
          res_num_q <= 32'(signed'(a_neg_q ? -{1'b0, a_mag_q} : {1'b0, a_mag_q}));
          res_den_q <= 31'(a_den_q);
        end else begin
          res_num_q <= r_neg_q ? 32'(-final_num) : 32'(final_num);
          res_den_q <= 31'(rd_q);
        end
      end
      default: ;
    endcase
  end

  assign sts_o.busy   = busy;
  assign sts_o.a_err  = a_err_q;
  assign sts_o.b_err  = b_err_q;
  assign sts_o.b_zero = (b_mag_q == '0);

  assign res_num_o = res_num_q;
  assign res_den_o = res_den_q;
  assign cmp_o     = cmp_q;
  assign status_o  = status_q;

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ctl_i.cmd == CMD_FINISH) && status_o != ST_OK |-> res_num_o == '0 && !cmp_o)
    else $error("error result not cleared");
  a_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ctl_i.cmd == CMD_FINISH) |-> res_den_o != '0)
    else $error("zero result denominator");
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.cmd == CMD_GSTEP |-> busy) else $error("step while unit idle");
endmodule

/* sv/rational_arithmetic_unit.sv */
`timescale 1ns / 1ps
// Rational arithmetic unit.
// Slave channel s_axis_*: one transfer carries an operation (tuser) and two
// fractions (tdata). Master channel m_axis_*: one transfer per input item
// with the reduced result, compare flag and status.
// Each item runs through a sequencer that reduces the left operand, the
// right operand and the result with one shared Euclid unit built on a
// bit-serial restoring divider (one quotient bit per cycle on 2*W+1 bits).
// Normalize reduces only the left operand; equality, a zero-denominator
// error or a division by zero skips the result reduction.
// Only one item is in flight; s_axis_tready is high while idle.
// The result sits in an output register; a stalled receiver holds it and
// the block waits to finish the next item until that register is free.
// Reset clears the sequencer and the output valid; no clearing pass.
module rational_arithmetic_unit #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // lhs_num, lhs_den, rhs_num, rhs_den
  input  logic [2:0]   s_axis_tuser,  // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // result_num, result_den, compare_true
  output logic [1:0]   m_axis_tuser   // status
);
  import rau_pkg::*;

  rau_ctl_t ctl;
  rau_sts_t sts;
  logic idle, done, in_fire, valid_q;
  logic [31:0] rnum;
  logic [30:0] rden;
  logic cmp;

  assign s_axis_tready = idle;
  assign in_fire = s_axis_tvalid && idle;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .op_i(s_axis_tuser),
    .out_free_i(!valid_q || m_axis_tready), .sts_i(sts), .ctl_o(ctl),
    .idle_o(idle), .done_o(done)
  );

  rau_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .op_i(s_axis_tuser),
    .an_i(s_axis_tdata[VALUE_WIDTH-1:0]),
    .ad_i(s_axis_tdata[32 +: VALUE_WIDTH]),
    .bn_i(s_axis_tdata[64 +: VALUE_WIDTH]),
    .bd_i(s_axis_tdata[96 +: VALUE_WIDTH]),
    .ctl_i(ctl), .sts_o(sts), .res_num_o(rnum), .res_den_o(rden),
    .cmp_o(cmp), .status_o(m_axis_tuser)
  );

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (done) valid_q <= 1'b1;
    else if (m_axis_tready) valid_q <= 1'b0;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {cmp, rden, rnum};

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped under stall");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !valid_q || m_axis_tready) else $error("result overwritten");
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready) else $error("second item taken");
endmodule
